// ===== hw/rtl/abcm_pkg.sv =====
package abcm_pkg;

   // calibration window, a power of two so the bias divide is a shift
   localparam int SAMPLE_LOG2  = 8;
   localparam int SAMPLE_COUNT = 1 << SAMPLE_LOG2;

   // datapath widths
   localparam int SAMPLE_W = 16;
   localparam int SUM_W    = SAMPLE_W + SAMPLE_LOG2;
   localparam int COUNT_W  = SAMPLE_LOG2 + 1;
   localparam int SQUARE_W = 2 * SAMPLE_W - 1;
   localparam int RAD_W    = 2 * SAMPLE_W;
   localparam int ROOT_W   = SAMPLE_W;
   localparam int ITER_W   = $clog2(ROOT_W);
   localparam int LANES    = 3;

   // control sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LANE,
      ST_SQUARE,
      ST_SUM,
      ST_ROOT,
      ST_DONE
   } state_type;

   // per-lane control from the sequencer
   typedef struct packed {
      logic load;
      logic accum;
      logic form;
      logic correct;
      logic square;
      logic calibrated;
   } lane_ctrl_type;

endpackage

// ===== hw/rtl/accel_bias_calibrate_magnitude.sv =====
// Accelerometer bias removal and vector magnitude.
// Input channel req_*: one beat carries a three-axis sample in req_tdata.
// Result channel rsp_*: one beat per input beat, the three axes and the
// magnitude in rsp_tdata, and the calibrated flag in rsp_tuser.
// The first SAMPLE_COUNT beats are summed per axis and returned raw; the
// next beat forms the per-axis bias and is also returned raw. Later beats
// are bias corrected, saturated, and carry the integer square root of the
// sum of squares; raw beats carry the last magnitude (zero after reset).
// Three axis lanes work side by side; a merge stage adds their squares and
// a shared bit-per-cycle square-root unit finishes the magnitude.
// Raw beats pass the lane correct register to the output register; corrected
// beats also pass the square register and the 16 square-root iterations. One beat is
// in flight at a time: a new beat is accepted only once the last one is loaded for output.
// A finished result sits in the output register while the next beat is
// accepted; if rsp_tready stays low, that next result waits in the lanes
// and req_tready stays low until the output register drains.
// Reset clears the sums, the sample count, the bias flag, the held
// magnitude and any pending result.
module accel_bias_calibrate_magnitude (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // accel_x, accel_y, accel_z
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // out_x, out_y, out_z, magnitude
   output logic        rsp_tuser    // calibrated
);

   abcm_pkg::state_type       state_ff;
   abcm_pkg::state_type       state_in;
   abcm_pkg::lane_ctrl_type   lane_ctrl;
   logic [abcm_pkg::COUNT_W-1:0] samples_ff;
   logic [abcm_pkg::COUNT_W-1:0] samples_in;
   logic                      bias_ready_ff;
   logic                      bias_ready_in;
   logic                      cal_item_ff;
   logic                      cal_item_in;
   logic [abcm_pkg::ROOT_W-1:0] held_ff;
   logic [abcm_pkg::ROOT_W-1:0] held_in;
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   logic [63:0]               rsp_data_ff;
   logic                      rsp_user_ff;
   logic                      rsp_load;
   logic                      req_accept;
   logic                      window_full;
   logic                      root_start;
   logic                      root_done;
   logic [abcm_pkg::ROOT_W-1:0] root;
   logic [abcm_pkg::RAD_W-1:0]  radicand;
   logic signed [abcm_pkg::SAMPLE_W-1:0] lane_sample    [abcm_pkg::LANES];
   logic signed [abcm_pkg::SAMPLE_W-1:0] lane_corrected [abcm_pkg::LANES];
   logic        [abcm_pkg::SQUARE_W-1:0] lane_square    [abcm_pkg::LANES];

   assign req_accept  = req_tvalid & req_tready;
   assign window_full = (samples_ff == abcm_pkg::COUNT_W'(abcm_pkg::SAMPLE_COUNT));

   // axis lanes
   for (genvar i = 0; i < abcm_pkg::LANES; i++) begin : g_lane
      assign lane_sample[i] = req_tdata[i*abcm_pkg::SAMPLE_W +: abcm_pkg::SAMPLE_W];
      abcm_lane u_lane (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (lane_ctrl),
         .sample_in (lane_sample[i]),
         .corrected (lane_corrected[i]),
         .square    (lane_square[i])
      );
   end

   // merge: sum of squares into the root unit
   assign radicand = abcm_pkg::RAD_W'(lane_square[0]) + abcm_pkg::RAD_W'(lane_square[1])
                   + abcm_pkg::RAD_W'(lane_square[2]);

   abcm_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (root_start),
      .radicand (radicand),
      .done     (root_done),
      .root     (root)
   );

   // sequencer
   always_comb begin
      state_in      = state_ff;
      samples_in    = samples_ff;
      bias_ready_in = bias_ready_ff;
      cal_item_in   = cal_item_ff;
      held_in       = held_ff;
      req_tready    = 1'b0;
      root_start    = 1'b0;
      rsp_load      = 1'b0;
      lane_ctrl     = '0;
      lane_ctrl.calibrated = cal_item_ff;
      unique case (state_ff)
         abcm_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               lane_ctrl.load  = 1'b1;
               lane_ctrl.accum = !bias_ready_ff && !window_full;
               lane_ctrl.form  = !bias_ready_ff && window_full;
               cal_item_in     = bias_ready_ff;
               if (!bias_ready_ff && !window_full) begin
                  samples_in = samples_ff + 1'b1;
               end
               if (!bias_ready_ff && window_full) begin
                  bias_ready_in = 1'b1;
               end
               state_in = abcm_pkg::ST_LANE;
            end
         end
         abcm_pkg::ST_LANE: begin
            lane_ctrl.correct = 1'b1;
            state_in = cal_item_ff ? abcm_pkg::ST_SQUARE : abcm_pkg::ST_DONE;
         end
         abcm_pkg::ST_SQUARE: begin
            lane_ctrl.square = 1'b1;
            state_in = abcm_pkg::ST_SUM;
         end
         abcm_pkg::ST_SUM: begin
            root_start = 1'b1;
            state_in   = abcm_pkg::ST_ROOT;
         end
         abcm_pkg::ST_ROOT: begin
            if (root_done) begin
               held_in  = root;
               state_in = abcm_pkg::ST_DONE;
            end
         end
         abcm_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = abcm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = abcm_pkg::ST_IDLE;
         end
      endcase
   end

   // output register valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= abcm_pkg::ST_IDLE;
         samples_ff    <= '0;
         bias_ready_ff <= 1'b0;
         cal_item_ff   <= 1'b0;
         held_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         samples_ff    <= samples_in;
         bias_ready_ff <= bias_ready_in;
         cal_item_ff   <= cal_item_in;
         held_ff       <= held_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // output beat payload
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= {held_ff, lane_corrected[2], lane_corrected[1], lane_corrected[0]};
         rsp_user_ff <= cal_item_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      samples_ff <= abcm_pkg::COUNT_W'(abcm_pkg::SAMPLE_COUNT))
      else $error("sample count past calibration window");

   a_cal_after_bias: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_user_ff |-> bias_ready_ff)
      else $error("corrected beat before bias formed");

   a_root_in_state: assert property (@(posedge clock) disable iff (reset)
      root_done |-> state_ff == abcm_pkg::ST_ROOT)
      else $error("root done outside root wait");

   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      state_ff == abcm_pkg::ST_DONE && rsp_valid_ff && !rsp_tready
      |=> state_ff == abcm_pkg::ST_DONE)
      else $error("result left while output register busy");

   a_bias_sticky: assert property (@(posedge clock) disable iff (reset)
      bias_ready_ff |=> bias_ready_ff)
      else $error("bias flag dropped");
`endif

endmodule

// ===== hw/rtl/abcm_lane.sv =====
module abcm_lane (
   input  logic                                  clock,
   input  logic                                  reset,
   input  abcm_pkg::lane_ctrl_type               ctrl,
   input  logic signed [abcm_pkg::SAMPLE_W-1:0]  sample_in,
   output logic signed [abcm_pkg::SAMPLE_W-1:0]  corrected,
   output logic        [abcm_pkg::SQUARE_W-1:0]  square
);

   logic signed [abcm_pkg::SAMPLE_W-1:0] sample_ff;
   logic signed [abcm_pkg::SUM_W-1:0]    sum_ff;
   logic signed [abcm_pkg::SUM_W-1:0]    sum_in;
   logic signed [abcm_pkg::SUM_W-1:0]    bias_round;
   logic signed [abcm_pkg::SAMPLE_W-1:0] bias_div;
   logic signed [abcm_pkg::SAMPLE_W-1:0] bias;
   logic signed [abcm_pkg::SAMPLE_W:0]   diff;
   logic signed [abcm_pkg::SAMPLE_W-1:0] sat;
   logic signed [abcm_pkg::SAMPLE_W-1:0] corrected_ff;
   logic signed [abcm_pkg::SAMPLE_W-1:0] corrected_in;
   logic signed [2*abcm_pkg::SAMPLE_W-1:0] product;
   logic        [abcm_pkg::SQUARE_W-1:0] square_ff;

   // running sum, then the bias truncated toward zero
   always_comb begin
      bias_round = sum_ff + (sum_ff[abcm_pkg::SUM_W-1] ?
                   abcm_pkg::SUM_W'(abcm_pkg::SAMPLE_COUNT - 1) : '0);
      bias_div   = bias_round[abcm_pkg::SUM_W-1:abcm_pkg::SAMPLE_LOG2];
      sum_in     = sum_ff;
      if (ctrl.accum) begin
         sum_in = sum_ff + abcm_pkg::SUM_W'(sample_in);
      end else if (ctrl.form) begin
         sum_in = abcm_pkg::SUM_W'(bias_div);
      end
   end

   // subtract bias and saturate to the sample range (raw beats keep the sample), then square
   always_comb begin
      bias = sum_ff[abcm_pkg::SAMPLE_W-1:0];
      diff = (abcm_pkg::SAMPLE_W+1)'(sample_ff) - (abcm_pkg::SAMPLE_W+1)'(bias);
      if (diff[abcm_pkg::SAMPLE_W] != diff[abcm_pkg::SAMPLE_W-1]) begin
         sat = diff[abcm_pkg::SAMPLE_W] ? {1'b1, {(abcm_pkg::SAMPLE_W-1){1'b0}}}
                                        : {1'b0, {(abcm_pkg::SAMPLE_W-1){1'b1}}};
      end else begin
         sat = diff[abcm_pkg::SAMPLE_W-1:0];
      end
      corrected_in = ctrl.calibrated ? sat : sample_ff;
      product      = corrected_ff * corrected_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else begin
         sum_ff <= sum_in;
      end
   end

   // sample, corrected value and square registers
   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         sample_ff <= sample_in;
      end
      if (ctrl.correct) begin
         corrected_ff <= corrected_in;
      end
      if (ctrl.square) begin
         square_ff <= product[abcm_pkg::SQUARE_W-1:0];
      end
   end

   assign corrected = corrected_ff;
   assign square    = square_ff;

endmodule

// ===== hw/rtl/abcm_isqrt.sv =====
module abcm_isqrt (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [abcm_pkg::RAD_W-1:0]        radicand,
   output logic                              done,
   output logic [abcm_pkg::ROOT_W-1:0]       root
);

   logic [abcm_pkg::RAD_W-1:0]    rad_ff;
   logic [abcm_pkg::RAD_W-1:0]    rad_in;
   logic [abcm_pkg::ROOT_W+1:0]   rem_ff;
   logic [abcm_pkg::ROOT_W+1:0]   rem_in;
   logic [abcm_pkg::ROOT_W-1:0]   root_ff;
   logic [abcm_pkg::ROOT_W-1:0]   root_in;
   logic [abcm_pkg::ITER_W-1:0]   iter_ff;
   logic [abcm_pkg::ITER_W-1:0]   iter_in;
   logic                          busy_ff;
   logic                          busy_in;
   logic                          done_ff;
   logic                          done_in;
   logic [abcm_pkg::ROOT_W+3:0]   cand;
   logic [abcm_pkg::ROOT_W+3:0]   trial;

   // one result bit per cycle, two radicand bits shifted in
   always_comb begin
      cand    = {rem_ff, rad_ff[abcm_pkg::RAD_W-1 -: 2]};
      trial   = {2'b00, root_ff, 2'b01};
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      iter_in = iter_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
         iter_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in = {rad_ff[abcm_pkg::RAD_W-3:0], 2'b00};
         if (cand >= trial) begin
            rem_in  = (abcm_pkg::ROOT_W+2)'(cand - trial);
            root_in = {root_ff[abcm_pkg::ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = (abcm_pkg::ROOT_W+2)'(cand);
            root_in = {root_ff[abcm_pkg::ROOT_W-2:0], 1'b0};
         end
         iter_in = iter_ff + 1'b1;
         if (iter_ff == abcm_pkg::ITER_W'(abcm_pkg::ROOT_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         iter_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         iter_ff <= iter_in;
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule
